### design/bcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bcc_pkg;

  localparam int unsigned MaxButtonsDefault = 16;
  localparam int unsigned QueueDepth        = 4;
  localparam int unsigned CfgIdxW           = 3;
  localparam int unsigned CfgDataW          = 64;
  localparam int unsigned BtnCountW         = 5;

  localparam logic [1:0] OpSample = 2'd0;
  localparam logic [1:0] OpPause  = 2'd1;
  localparam logic [1:0] OpResume = 2'd2;

  localparam logic [1:0] EvPressed      = 2'd0;
  localparam logic [1:0] EvClick        = 2'd1;
  localparam logic [1:0] EvLongClick    = 2'd2;
  localparam logic [1:0] EvShortRelease = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgButtonCount   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPinSelect     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgActiveLevels  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgClickTime     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLongClickTime = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMultiClickGap = 3'd5;

  localparam logic [15:0] HeldMax  = 16'hFFFF;
  localparam logic [7:0]  CountMax = 8'hFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] pin_levels;
    logic [31:0] elapsed_ms;
    logic [3:0]  button_index;
  } in_item_t;

  typedef struct packed {
    logic [3:0] button;
    logic [1:0] event_kind;
    logic [7:0] click_count;
    logic       last_of_run;
  } out_item_t;

endpackage
`default_nettype wire

### design/button_click_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | in_item_i  (bcc_pkg::in_item_t)
// out     | output    | out_valid_o / out_stall_i | out_item_o (bcc_pkg::out_item_t)
// cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// A sample request scans N = min(button_count, MAX_BUTTONS) buttons: the front scans one button
// per cycle, barring queue-full stalls, through a single shared update unit.
// A scan step that emits an event waits while the event queue is full.
// Reset clears all button state at once; no clearing pass.
// The output register holds the current event while out_stall_i is high; the queue backs up.
module button_click_classifier #(
  parameter int unsigned MAX_BUTTONS = bcc_pkg::MaxButtonsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire bcc_pkg::in_item_t            in_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output bcc_pkg::out_item_t                out_item_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [bcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bcc_pkg::CfgDataW-1:0] cfg_data_i
);
  import bcc_pkg::*;

  logic      push;
  out_item_t push_item;
  logic      full;
  logic      q_valid;
  out_item_t q_item;
  logic      q_pop;

  bcc_front #(
    .MAX_BUTTONS(MAX_BUTTONS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  bcc_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  bcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

### design/bcc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bcc_front #(
  parameter int unsigned MAX_BUTTONS = bcc_pkg::MaxButtonsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bcc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire bcc_pkg::in_item_t            in_item_i,
  output logic                              push_o,
  output bcc_pkg::out_item_t                push_item_o,
  input  wire logic                         full_i
);
  import bcc_pkg::*;

  localparam int unsigned IdxW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;

  logic [BtnCountW-1:0] button_count_q;
  logic [63:0]          pin_select_q;
  logic [15:0]          active_levels_q;
  logic [15:0]          click_time_q;
  logic [15:0]          long_click_time_q;
  logic [15:0]          multi_click_gap_q;

  logic [MAX_BUTTONS-1:0] pressed_q;
  logic [MAX_BUTTONS-1:0] paused_q;
  logic [7:0]             count_q [MAX_BUTTONS];
  logic [15:0]            held_q  [MAX_BUTTONS];

  logic                   busy_q;
  logic [BtnCountW-1:0]   scan_q;
  logic [15:0]            levels_q;
  logic [31:0]            elapsed_q;
  logic [MAX_BUTTONS-1:0] mask_q;
  logic [MAX_BUTTONS-1:0] mask_c;

  logic [BtnCountW-1:0] nb;
  logic                 accept;
  logic                 ctrl_hit;
  logic [IdxW-1:0]      ctrl_idx;
  logic [IdxW-1:0]      cur;
  logic [16:0]          sum;
  logic [15:0]          held_new;
  logic                 hit;
  logic                 emit;
  logic                 step;
  logic                 scan_end;
  logic [7:0]           cnt_inc;
  logic [7:0]           cnt_new;
  logic [MAX_BUTTONS-1:0] mask_left;

  assign nb = (button_count_q > BtnCountW'(MAX_BUTTONS)) ? BtnCountW'(MAX_BUTTONS)
                                                          : button_count_q;
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign ctrl_hit   = {1'b0, in_item_i.button_index} < nb;
  assign ctrl_idx   = in_item_i.button_index[IdxW-1:0];

  always_comb begin
    for (int b = 0; b < MAX_BUTTONS; b++) begin
      mask_c[b] = (BtnCountW'(b) < nb) && !paused_q[b] &&
                  ((in_item_i.pin_levels[pin_select_q[b*4 +: 4]] == active_levels_q[b])
                   != pressed_q[b]);
    end
  end

  assign cur      = scan_q[IdxW-1:0];
  assign sum      = {1'b0, held_q[cur]} + {1'b0, elapsed_q[15:0]};
  assign held_new = ((|elapsed_q[31:16]) || (sum >= {1'b0, HeldMax})) ? HeldMax : sum[15:0];
  assign hit      = levels_q[pin_select_q[cur*4 +: 4]] == active_levels_q[cur];
  assign emit     = busy_q && mask_q[cur];
  assign step     = busy_q && !(emit && full_i);
  assign scan_end = scan_q == (nb - BtnCountW'(1));
  assign cnt_inc  = (count_q[cur] == CountMax) ? count_q[cur] : count_q[cur] + 8'd1;

  always_comb begin
    mask_left = mask_q;
    mask_left[cur] = 1'b0;
  end

  always_comb begin
    push_o                  = emit && !full_i;
    push_item_o.button      = 4'(cur);
    push_item_o.last_of_run = mask_left == '0;
    push_item_o.event_kind  = EvShortRelease;
    push_item_o.click_count = 8'd0;
    cnt_new                 = count_q[cur];
    if (hit) begin
      push_item_o.event_kind = EvPressed;
      if (held_new > multi_click_gap_q) begin
        cnt_new = 8'd0;
      end
    end else if (held_new >= long_click_time_q) begin
      push_item_o.event_kind  = EvLongClick;
      push_item_o.click_count = count_q[cur];
      cnt_new                 = 8'd0;
    end else if (held_new >= click_time_q) begin
      push_item_o.event_kind  = EvClick;
      push_item_o.click_count = cnt_inc;
      cnt_new                 = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_count_q    <= '0;
      pin_select_q      <= '0;
      active_levels_q   <= '0;
      click_time_q      <= 16'd50;
      long_click_time_q <= 16'd1000;
      multi_click_gap_q <= 16'd500;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgButtonCount:   button_count_q    <= cfg_data_i[BtnCountW-1:0];
        CfgPinSelect:     pin_select_q      <= cfg_data_i;
        CfgActiveLevels:  active_levels_q   <= cfg_data_i[15:0];
        CfgClickTime:     click_time_q      <= cfg_data_i[15:0];
        CfgLongClickTime: long_click_time_q <= cfg_data_i[15:0];
        CfgMultiClickGap: multi_click_gap_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.operation == OpSample) begin
      levels_q  <= in_item_i.pin_levels;
      elapsed_q <= in_item_i.elapsed_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      scan_q    <= '0;
      mask_q    <= '0;
      pressed_q <= '0;
      paused_q  <= '0;
      for (int b = 0; b < MAX_BUTTONS; b++) begin
        count_q[b] <= 8'd0;
        held_q[b]  <= 16'd0;
      end
    end else if (accept) begin
      case (in_item_i.operation)
        OpSample: begin
          busy_q <= nb != '0;
          scan_q <= '0;
          mask_q <= mask_c;
        end
        OpPause: begin
          if (ctrl_hit) begin
            paused_q[ctrl_idx] <= 1'b1;
          end
        end
        OpResume: begin
          if (ctrl_hit) begin
            paused_q[ctrl_idx]  <= 1'b0;
            pressed_q[ctrl_idx] <= 1'b0;
            held_q[ctrl_idx]    <= 16'd0;
          end
        end
        default: ;
      endcase
    end else if (step) begin
      if (emit) begin
        pressed_q[cur] <= hit;
        held_q[cur]    <= 16'd0;
        count_q[cur]   <= cnt_new;
        mask_q         <= mask_left;
      end else if (!paused_q[cur]) begin
        held_q[cur] <= held_new;
      end
      if (scan_end) begin
        busy_q <= 1'b0;
      end else begin
        scan_q <= scan_q + BtnCountW'(1);
      end
    end
  end

  a_idle_mask_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> mask_q == '0) else $error("pending events left after scan");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> scan_q < nb) else $error("scan index beyond scanned buttons");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_item_o.last_of_run |=> mask_q == '0)
    else $error("events remain after last of run");

endmodule
`default_nettype wire

### design/bcc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bcc_queue #(
  parameter int unsigned DEPTH = bcc_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire bcc_pkg::out_item_t push_item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output bcc_pkg::out_item_t      item_o
);
  import bcc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  out_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntW'(DEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH)) else $error("queue count overflow");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("pop from empty queue");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

endmodule
`default_nettype wire

### design/bcc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bcc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire bcc_pkg::out_item_t q_item_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output bcc_pkg::out_item_t      out_item_o
);
  import bcc_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  assign q_pop_o     = q_valid_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire
